/* hw/rtl/rgpd_pkg.sv */
// ----------------------------------------------------------------------------
// rgpd_pkg: shared types and constants for the RSSI gate pass detector
// Beat payload structs, configuration register indexes and rearm constants.
// ----------------------------------------------------------------------------
package rgpd_pkg;

  // Configuration port geometry
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_THRESHOLD  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MIN_LAP_MS = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ENABLED    = 2'd2;

  // Rearm level: threshold minus max(3 percent, 30 counts)
  localparam logic [15:0] PCT_KNEE   = 16'd1000;  // 3 percent wins from here up
  localparam logic [22:0] REARM_NUM  = 23'd97;
  localparam logic [22:0] REARM_DEN  = 23'd100;
  localparam logic [16:0] HYST_FLOOR = 17'd30;

  // Input beat
  typedef struct packed {
    logic [15:0] rssi;
    logic [31:0] now_ms;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic [15:0] peak_level;
    logic [31:0] crossed_at_ms;
    logic [15:0] pass_number;
  } out_beat_t;

endpackage

/* hw/rtl/rssi_gate_pass_detector.sv */
// ----------------------------------------------------------------------------
// rssi_gate_pass_detector: threshold and hysteresis pass detector
// Arms above threshold, tracks the peak, and reports one pass per completed
// crossing unless it follows the previous pass by less than the minimum lap.
// ----------------------------------------------------------------------------
// Throughput: 1 input beat per cycle; an input register and a result
// register bracket the compare and subtract logic on the detector state.
// Each beat is registered at the input, any pass it ends at the result.
// Input stalls only while the result register is full and stalled.
// Reset clears configuration (detection disabled) and all pass history.
module rssi_gate_pass_detector (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  rgpd_pkg::in_beat_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output rgpd_pkg::out_beat_t               out_data_o,
  input  logic                              cfg_we_i,
  input  logic [rgpd_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [rgpd_pkg::CfgDataW-1:0]     cfg_data_i
);

  // Configuration registers
  logic [15:0] thr_q, thr_d;
  logic [31:0] min_lap_q, min_lap_d;
  logic        enabled_q, enabled_d;

  // Detector state
  logic        armed_q, armed_d;
  logic [15:0] peak_q, peak_d;
  logic [31:0] cross_q, cross_d;
  logic [31:0] last_q, last_d;
  logic        have_q, have_d;
  logic [15:0] passes_q, passes_d;

  // Input stage
  logic                s1_valid_q, s1_valid_d;
  rgpd_pkg::in_beat_t  s1_data_q;

  // Result stage
  logic                out_valid_q, out_valid_d;
  rgpd_pkg::out_beat_t out_data_q;

  logic                out_ready;
  logic                s1_take;
  logic                fire;
  rgpd_pkg::out_beat_t res;
  logic [15:0]         peak_cur;
  logic                in_gate;
  logic                lap_short;
  logic [31:0]         lap_gap;
  logic [15:0]         passes_inc;

  // Handshake: result register frees when empty or taken
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_take    = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;

  // Rearm test on the registered sample
  always_comb begin
    if (thr_q >= rgpd_pkg::PCT_KNEE) begin
      in_gate = (23'(s1_data_q.rssi) * rgpd_pkg::REARM_DEN) >=
                (23'(thr_q) * rgpd_pkg::REARM_NUM);
    end else begin
      in_gate = ({1'b0, s1_data_q.rssi} + rgpd_pkg::HYST_FLOOR) >= {1'b0, thr_q};
    end
  end

  assign peak_cur   = (s1_data_q.rssi > peak_q) ? s1_data_q.rssi : peak_q;
  assign lap_gap    = cross_q - last_q;
  assign lap_short  = have_q && (min_lap_q != 32'd0) && (lap_gap < min_lap_q);
  assign passes_inc = passes_q + 16'd1;

  // Configuration writes
  always_comb begin
    thr_d     = thr_q;
    min_lap_d = min_lap_q;
    enabled_d = enabled_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rgpd_pkg::CFG_THRESHOLD:  thr_d     = cfg_data_i[15:0];
        rgpd_pkg::CFG_MIN_LAP_MS: min_lap_d = cfg_data_i;
        rgpd_pkg::CFG_ENABLED:    enabled_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Writes first; else consumed samples advance state when enabled, thr > 0
  always_comb begin
    armed_d  = armed_q;
    peak_d   = peak_q;
    cross_d  = cross_q;
    last_d   = last_q;
    have_d   = have_q;
    passes_d = passes_q;
    fire     = 1'b0;
    res.peak_level    = peak_cur;
    res.crossed_at_ms = cross_q;
    res.pass_number   = passes_inc;
    if (cfg_we_i) begin
      // any valid register write drops the crossing in progress
      if (cfg_idx_i == rgpd_pkg::CFG_THRESHOLD || cfg_idx_i == rgpd_pkg::CFG_MIN_LAP_MS ||
          cfg_idx_i == rgpd_pkg::CFG_ENABLED) begin
        armed_d = 1'b0;
        peak_d  = 16'd0;
      end
    end else if (s1_take && enabled_q && (thr_q != 16'd0)) begin
      if (!armed_q) begin
        if (s1_data_q.rssi > thr_q) begin
          armed_d = 1'b1;
          peak_d  = s1_data_q.rssi;
          cross_d = s1_data_q.now_ms;
        end
      end else begin
        peak_d = peak_cur;
        if (!in_gate) begin
          armed_d = 1'b0;
          peak_d  = 16'd0;
          if (!lap_short) begin
            last_d   = cross_q;
            have_d   = 1'b1;
            passes_d = passes_inc;
            fire     = 1'b1;
          end
        end
      end
    end
  end

  // Input and result stage control
  always_comb begin
    s1_valid_d  = in_stall_o ? s1_valid_q : in_valid_i;
    out_valid_d = out_ready ? (s1_take && fire) : out_valid_q;
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= '0;
      min_lap_q   <= '0;
      enabled_q   <= 1'b0;
      armed_q     <= 1'b0;
      peak_q      <= '0;
      cross_q     <= '0;
      last_q      <= '0;
      have_q      <= 1'b0;
      passes_q    <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      thr_q       <= thr_d;
      min_lap_q   <= min_lap_d;
      enabled_q   <= enabled_d;
      armed_q     <= armed_d;
      peak_q      <= peak_d;
      cross_q     <= cross_d;
      last_q      <= last_d;
      have_q      <= have_d;
      passes_q    <= passes_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: load on accepted beat / fired result
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_data_q <= in_data_i;
    end
    if (s1_take && fire) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* hw/rtl/rgpd_checker.sv */
// ----------------------------------------------------------------------------
// rgpd_checker: port-level checks for the RSSI gate pass detector
// Watches beats on both channels and checks stall, timing and pass counting.
// ----------------------------------------------------------------------------
module rgpd_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_o,
  input  logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  rgpd_pkg::out_beat_t           out_data_o
);

  logic        out_beat;
  logic        seen_q;
  logic [15:0] last_num_q;

  assign out_beat = out_valid_o && !out_stall_i;

  // Track the pass number of the last delivered result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= 1'b0;
      last_num_q <= '0;
    end else if (out_beat) begin
      seen_q     <= 1'b1;
      last_num_q <= out_data_o.pass_number;
    end
  end

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // Input only stalls behind a full, stalled result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without downstream backpressure");

  // A fresh result follows an accepted input beat through both registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result beat without matching input beat");

  // Pass numbers advance by one per delivered result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && seen_q |-> out_data_o.pass_number == last_num_q + 16'd1)
    else $error("pass number did not advance by one");

endmodule

bind rssi_gate_pass_detector rgpd_checker u_rgpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

/* tb/sv/tb_rssi_gate_pass_detector.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rssi_gate_pass_detector: self-checking bench for the RSSI pass detector
// Drives sample beats in random bursts against a randomly stalling result
// side. A scoreboard class mirrors the detector state and the configuration,
// queues the pass beats each sample should cause, and checks every result
// beat field by field. Configuration changes happen only between phases,
// once the block has drained.
// ----------------------------------------------------------------------------
module tb_rssi_gate_pass_detector;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned NumSamples  = 900;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned LongHold    = 400;

  // Index past the end of the register list; a write there must do nothing
  localparam logic [rgpd_pkg::CfgIdxW-1:0] CFG_UNUSED = 2'd3;

  // Scoreboard: mirror of the detector state and the expected pass beats
  class pass_tracker;
    logic [15:0]         thr;
    logic [31:0]         min_lap;
    logic                en;
    logic                armed;
    logic [15:0]         peak;
    logic [31:0]         t_cross;
    logic [31:0]         t_last;
    logic                have_pass;
    logic [15:0]         passes;
    rgpd_pkg::out_beat_t expected_passes[$];
    int unsigned         errors;

    function new();
      thr       = '0;
      min_lap   = '0;
      en        = 1'b0;
      armed     = 1'b0;
      peak      = '0;
      t_cross   = '0;
      t_last    = '0;
      have_pass = 1'b0;
      passes    = '0;
      errors    = 0;
    endfunction

    // Apply a register write; any valid index also drops the open crossing
    function void write_reg(logic [rgpd_pkg::CfgIdxW-1:0] idx,
                            logic [rgpd_pkg::CfgDataW-1:0] data);
      case (idx)
        rgpd_pkg::CFG_THRESHOLD: begin
          thr = data[15:0];
        end
        rgpd_pkg::CFG_MIN_LAP_MS: begin
          min_lap = data;
        end
        rgpd_pkg::CFG_ENABLED: begin
          en = data[0];
        end
        default: begin
          return;
        end
      endcase
      armed = 1'b0;
      peak  = '0;
    endfunction

    // True while the sample stays at or above the rearm level
    function bit in_gate(logic [15:0] lvl);
      if (thr >= rgpd_pkg::PCT_KNEE) return (32'(lvl) * 32'd100) >= (32'(thr) * 32'd97);
      return (32'(lvl) + 32'd30) >= 32'(thr);
    endfunction

    // Advance the mirror by one accepted sample and queue any pass it ends
    function void note_sample(rgpd_pkg::in_beat_t b);
      rgpd_pkg::out_beat_t r;
      logic [31:0]         lap;
      if (!en || thr == '0) return;
      if (!armed) begin
        if (b.rssi > thr) begin
          armed   = 1'b1;
          peak    = b.rssi;
          t_cross = b.now_ms;
        end
        return;
      end
      if (b.rssi > peak) peak = b.rssi;
      if (in_gate(b.rssi)) return;
      armed        = 1'b0;
      r.peak_level = peak;
      peak         = '0;
      lap          = t_cross - t_last;
      // Drop a pass that comes too soon after the last accepted one
      if (have_pass && min_lap != '0 && lap < min_lap) return;
      t_last          = t_cross;
      have_pass       = 1'b1;
      passes          = passes + 16'd1;
      r.crossed_at_ms = t_cross;
      r.pass_number   = passes;
      expected_passes.push_back(r);
    endfunction

    // Compare one accepted result beat with the oldest expected pass
    function void check_pass(rgpd_pkg::out_beat_t got);
      rgpd_pkg::out_beat_t want;
      if (expected_passes.size() == 0) begin
        $error("unexpected result beat: peak_level=%0d crossed_at_ms=%0d pass_number=%0d",
               got.peak_level, got.crossed_at_ms, got.pass_number);
        errors++;
        return;
      end
      want = expected_passes.pop_front();
      if (got.peak_level !== want.peak_level) begin
        $error("peak_level mismatch: expected %0d, actual %0d",
               want.peak_level, got.peak_level);
        errors++;
      end
      if (got.crossed_at_ms !== want.crossed_at_ms) begin
        $error("crossed_at_ms mismatch: expected %0d, actual %0d",
               want.crossed_at_ms, got.crossed_at_ms);
        errors++;
      end
      if (got.pass_number !== want.pass_number) begin
        $error("pass_number mismatch: expected %0d, actual %0d",
               want.pass_number, got.pass_number);
        errors++;
      end
    endfunction

    function int pending();
      return expected_passes.size();
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid;
  logic                          in_stall;
  rgpd_pkg::in_beat_t            in_data;
  logic                          out_valid;
  logic                          out_stall;
  rgpd_pkg::out_beat_t           out_data;
  logic                          cfg_we;
  logic [rgpd_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [rgpd_pkg::CfgDataW-1:0] cfg_data;

  pass_tracker tracker;
  int unsigned cycle_cnt = 0;
  bit          hold_req;
  int          burst_left;
  int          counted;
  logic [15:0] cur_thr;
  logic        cur_en;
  logic [31:0] t_now;

  rssi_gate_pass_detector uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Count cycles and abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("simulation failed");
    $finish;
  end

  // Observe both handshakes at the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) tracker.note_sample(in_data);
      if (out_valid && !out_stall) tracker.check_pass(out_data);
    end
  end

  // Result side: stall pattern of its own, plus one long hold on request
  initial begin
    int pct;
    int len;
    out_stall <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
      end else begin
        case ($urandom_range(4, 0))
          0: pct = 0;
          1: pct = 20;
          2: pct = 50;
          3: pct = 85;
          default: pct = 5;
        endcase
        len = $urandom_range(200, 5);
        repeat (len) begin
          // Start a requested hold right away, while the sender keeps going
          if (hold_req) break;
          out_stall <= ($urandom_range(99, 0) < pct);
          @(posedge clk_i);
        end
      end
    end
  end

  // Present one sample beat and hold it until accepted
  task automatic send_sample(input logic [15:0] lvl, input logic [31:0] ts);
    in_data  <= rgpd_pkg::in_beat_t'{rssi: lvl, now_ms: ts};
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
  endtask

  // Send within bursts, with a random gap whenever a burst runs out
  task automatic offer(input logic [15:0] lvl, input logic [31:0] ts);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(9, 0) == 0) ? $urandom_range(30, 10) : $urandom_range(4, 0);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
    end
    burst_left--;
    if (cur_en && cur_thr != '0) counted++;
    send_sample(lvl, ts);
  endtask

  // Drop valid, wait for every expected pass, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (tracker.pending() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // One register write on an idle block
  task automatic write_reg(input logic [rgpd_pkg::CfgIdxW-1:0]  idx,
                           input logic [rgpd_pkg::CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    tracker.write_reg(idx, data);
    case (idx)
      rgpd_pkg::CFG_THRESHOLD: begin
        cur_thr = data[15:0];
      end
      rgpd_pkg::CFG_ENABLED: begin
        cur_en = data[0];
      end
      default: begin
      end
    endcase
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // One crossing attempt: rise above threshold, linger, fall below rearm
  task automatic crossing();
    int lo_max;
    int n;
    lo_max = (cur_thr >= rgpd_pkg::PCT_KNEE) ? (97 * int'(cur_thr) + 99) / 100 - 1
                                             : int'(cur_thr) - 31;
    n = $urandom_range(4, 1);
    repeat (n) begin
      t_now += $urandom_range(40, 0);
      if (cur_thr == 16'hFFFF) offer(16'($urandom_range(65535, 0)), t_now);
      else offer(16'($urandom_range(65535, int'(cur_thr) + 1)), t_now);
    end
    // Dip into the hysteresis band without ending the crossing
    repeat ($urandom_range(2, 0)) begin
      t_now += $urandom_range(40, 0);
      offer(16'($urandom_range(int'(cur_thr), (lo_max < 0) ? 0 : lo_max + 1)), t_now);
    end
    t_now += $urandom_range(40, 0);
    if (lo_max >= 0) offer(16'($urandom_range(lo_max, 0)), t_now);
    else offer(16'($urandom_range(65535, 0)), t_now);
  endtask

  // Stimulus
  initial begin
    int          phase;
    int          k;
    int          target;
    int          first;
    logic [15:0] thr;
    logic [31:0] lap;
    logic        en;
    logic [31:0] junk;

    tracker    = new();
    hold_req   = 1'b0;
    burst_left = 0;
    counted    = 0;
    cur_thr    = '0;
    cur_en     = 1'b0;
    t_now      = '0;
    rst_ni   <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    cfg_we   <= 1'b0;
    cfg_idx  <= '0;
    cfg_data <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Out of reset detection is off
    send_sample(16'd40000, 32'd5);
    settle();
    // Threshold set but still disabled
    write_reg(rgpd_pkg::CFG_THRESHOLD, {16'hA5A5, 16'd1000});
    send_sample(16'd2000, 32'd15);
    settle();
    // Threshold at the knee: percent hysteresis, exact boundary at 970
    write_reg(rgpd_pkg::CFG_ENABLED, 32'hFFFF_FFFF);
    send_sample(16'd1000, 32'd10);
    send_sample(16'd1001, 32'd20);
    send_sample(16'd65535, 32'd30);
    send_sample(16'd970, 32'd40);
    send_sample(16'd969, 32'd50);
    settle();
    // Just below the knee: 30-count hysteresis
    write_reg(rgpd_pkg::CFG_THRESHOLD, 32'd999);
    send_sample(16'd1000, 32'd60);
    send_sample(16'd969, 32'd70);
    send_sample(16'd968, 32'd80);
    settle();
    // Smallest threshold whose rearm level is above zero
    write_reg(rgpd_pkg::CFG_THRESHOLD, 32'd31);
    send_sample(16'd32, 32'd90);
    send_sample(16'd0, 32'd100);
    settle();
    // Rearm level at zero: the crossing never ends
    write_reg(rgpd_pkg::CFG_THRESHOLD, 32'd30);
    send_sample(16'd65535, 32'd110);
    send_sample(16'd0, 32'd120);
    settle();
    // Full-scale threshold can never arm
    write_reg(rgpd_pkg::CFG_THRESHOLD, 32'hFFFF_FFFF);
    send_sample(16'd65535, 32'd130);
    settle();
    // Zero threshold ignores samples
    write_reg(rgpd_pkg::CFG_THRESHOLD, 32'd0);
    send_sample(16'd50000, 32'd140);
    settle();
    // Minimum lap across the clock wrap: second pass comes too soon
    write_reg(rgpd_pkg::CFG_THRESHOLD, 32'd500);
    write_reg(rgpd_pkg::CFG_MIN_LAP_MS, 32'd100);
    send_sample(16'd501, 32'hFFFF_FFF0);
    send_sample(16'd0, 32'hFFFF_FFF5);
    send_sample(16'd600, 32'h0000_0010);
    send_sample(16'd0, 32'h0000_0020);
    settle();
    // Largest minimum lap, met only by an interval of all ones
    write_reg(rgpd_pkg::CFG_MIN_LAP_MS, 32'hFFFF_FFFF);
    send_sample(16'd501, 32'hFFFF_FFEF);
    send_sample(16'd0, 32'hFFFF_FFF8);
    settle();
    // A register write drops an open crossing
    send_sample(16'd700, 32'd1000);
    settle();
    write_reg(rgpd_pkg::CFG_MIN_LAP_MS, 32'd0);
    send_sample(16'd0, 32'd1010);
    settle();
    // A write past the register list leaves the crossing open
    send_sample(16'd700, 32'd1020);
    settle();
    write_reg(CFG_UNUSED, $urandom);
    send_sample(16'd0, 32'd1030);

    // Random phases, each with a fresh setting of every register
    phase = 0;
    t_now = $urandom;
    while (counted < NumSamples) begin
      settle();
      thr = 16'($urandom_range(4000, 31));
      case ($urandom_range(9, 0))
        0: thr = 16'd0;
        1: thr = 16'($urandom_range(30, 1));
        2: thr = 16'd999;
        3: thr = 16'd1000;
        4: thr = 16'hFFFF;
        5: thr = 16'($urandom_range(65534, 60000));
        default: begin
        end
      endcase
      case ($urandom_range(3, 0))
        0: lap = 32'd0;
        1: lap = $urandom_range(400, 1);
        2: lap = 32'hFFFF_FFFF;
        default: lap = $urandom;
      endcase
      en = ($urandom_range(6, 0) != 0);
      case (phase)
        0: begin
          thr = 16'd1;
          lap = 32'hFFFF_FFFF;
          en  = 1'b1;
        end
        1: begin
          thr = 16'd65535;
        end
        4: begin
          thr = 16'd200;
          lap = 32'd0;
          en  = 1'b1;
        end
        default: begin
        end
      endcase
      // Write all three in a rotated order, junk in the unused upper bits
      first = $urandom_range(2, 0);
      for (k = 0; k < 3; k++) begin
        junk = $urandom;
        case ((first + k) % 3)
          0: write_reg(rgpd_pkg::CFG_THRESHOLD, {junk[31:16], thr});
          1: write_reg(rgpd_pkg::CFG_MIN_LAP_MS, lap);
          default: write_reg(rgpd_pkg::CFG_ENABLED, {junk[31:1], en});
        endcase
      end
      if ($urandom_range(3, 0) == 0) write_reg(CFG_UNUSED, $urandom);

      target = (cur_en && cur_thr != '0) ? 15 : 4;
      for (k = 0; k < target; k++) begin
        if (phase == 4 && k == 5) hold_req = 1'b1;
        // Occasionally pause the sender until every pass has come out
        if (k == target / 2 && $urandom_range(3, 0) == 0) settle();
        if ($urandom_range(4, 0) == 0) begin
          if ($urandom_range(3, 0) == 0) t_now = $urandom;
          else t_now += $urandom_range(40, 0);
          offer(16'($urandom), t_now);
        end else begin
          crossing();
        end
      end
      phase++;
    end

    settle();
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/rgpd_pkg.sv
hw/rtl/rssi_gate_pass_detector.sv
hw/rtl/rgpd_checker.sv
tb/sv/tb_rssi_gate_pass_detector.sv
